// ===== design/salc_pkg.sv =====
// Shared types and constants for the set-associative tag store with LRU.
// No dependencies; the design files that use it refer to it by scoped names, the bench files import it.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

   localparam int ADDR_W    = 32;
   localparam int TAG_W     = 32;
   localparam int AGE_W     = 3;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;
   localparam int WAY_OUT_W = 3;
   // raw set index before the wrap to the set count: at most 15 index bits
   localparam int RAW_SET_W = 15;
   localparam int SHIFT_W   = 5;

   localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX   = 1'b1;

   localparam logic [CFG_W-1:0] LINE_OFFSET_RESET = 4'd6;
   localparam logic [CFG_W-1:0] SET_INDEX_RESET   = 4'd6;

   // one way of a set row as kept in the tag memory
   typedef struct packed {
      logic             valid;
      logic [AGE_W-1:0] age;
      logic [TAG_W-1:0] tag;
   } way_entry_type;

   localparam int ENTRY_W = $bits(way_entry_type);

   // one lookup response
   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way_used;
      logic                 evicted;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } back_state_type;

endpackage

`default_nettype wire

// ===== design/set_assoc_cache_lru_lookup.sv =====
// Path: front stages a and b, the mid queue, the back end, then the response queue.
// The back end takes a new request only after the read, match and write-back
//   of the last one on the single tag row memory (one set row per pass).
// Reset: split registers return to 6 and 6; a clearing pass then zeroes one
//   set row per cycle over all MAX_SETS rows, with full held high meanwhile.
// Top level; depends on salc_pkg, salc_front, salc_fifo, salc_back, salc_ram.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_lookup #(
   parameter int WAYS = 8,
   parameter int MAX_SETS = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request side
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic [salc_pkg::ADDR_W-1:0]       req_address,
   // response side
   output logic                                   empty,
   input  wire logic                              pop,
   output logic                                   rsp_hit,
   output logic      [salc_pkg::WAY_OUT_W-1:0]    rsp_way_used,
   output logic                                   rsp_evicted,
   // register writes
   input  wire logic                              csr_wr_en,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [salc_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int ROW_W = WAYS * salc_pkg::ENTRY_W;
   localparam int MID_W = salc_pkg::TAG_W + SET_W;

   // front side
   logic                       front_full;
   logic                       accept;
   logic                       clearing;

   // front to back queue
   logic                       mid_push, mid_full, mid_pop, mid_empty;
   logic [salc_pkg::TAG_W-1:0] mid_tag_w;
   logic [SET_W-1:0]           mid_set_w;
   logic [MID_W-1:0]           mid_rd;

   // back to response queue
   logic                       out_push, out_full;
   salc_pkg::rsp_type          out_data;
   logic [salc_pkg::RSP_W-1:0] rsp_vec;
   salc_pkg::rsp_type          rsp_word;

   // tag row memory
   logic                       ram_wr_en, ram_rd_en;
   logic [SET_W-1:0]           ram_wr_addr, ram_rd_addr;
   logic [ROW_W-1:0]           ram_wr_data, ram_rd_data;

   // no request is taken while the tag memory is being cleared
   assign full   = front_full || clearing;
   assign accept = push && !full;

   salc_front #(
      .MAX_SETS (MAX_SETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_push    (accept),
      .in_address (req_address),
      .in_full    (front_full),
      .q_full     (mid_full),
      .q_push     (mid_push),
      .q_tag      (mid_tag_w),
      .q_set      (mid_set_w)
   );

   // short queue so the front keeps taking requests while the back works
   salc_fifo #(
      .WIDTH (MID_W),
      .DEPTH (2)
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data ({mid_tag_w, mid_set_w}),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   salc_back #(
      .WAYS     (WAYS),
      .MAX_SETS (MAX_SETS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (mid_empty),
      .q_tag       (mid_rd[MID_W-1:SET_W]),
      .q_set       (mid_rd[SET_W-1:0]),
      .q_pop       (mid_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_data    (out_data),
      .clearing    (clearing),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // one row per set: valid, age and tag of every way
   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response queue: results wait here while the next request proceeds
   salc_fifo #(
      .WIDTH (salc_pkg::RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_vec),
      .empty   (empty)
   );

   assign rsp_word     = salc_pkg::rsp_type'(rsp_vec);
   assign rsp_hit      = rsp_word.hit;
   assign rsp_way_used = rsp_word.way_used;
   assign rsp_evicted  = rsp_word.evicted;

endmodule

`default_nettype wire

// ===== design/salc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/salc_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// No dependencies; used between front and back and on the response side.
`timescale 1ns / 1ps
`default_nettype none

module salc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/salc_front.sv =====
// Front end: split registers, address split into tag and set, set wrap.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salc_front #(
   parameter int MAX_SETS = 256,
   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [salc_pkg::CFG_W-1:0]         csr_wdata,
   input  wire logic                               in_push,
   input  wire logic [salc_pkg::ADDR_W-1:0]        in_address,
   output logic                                    in_full,
   input  wire logic                               q_full,
   output logic                                    q_push,
   output logic      [salc_pkg::TAG_W-1:0]         q_tag,
   output logic      [SET_W-1:0]                   q_set
);

   localparam int RW = salc_pkg::RAW_SET_W;

   logic [salc_pkg::CFG_W-1:0]   off_ff, sib_ff;
   logic                         a_valid_ff, a_valid_in;
   logic [salc_pkg::TAG_W-1:0]   a_tag_ff;
   logic [RW-1:0]                a_raw_ff;
   logic                         b_valid_ff, b_valid_in;
   logic [salc_pkg::TAG_W-1:0]   b_tag_ff;
   logic [RW-1:0]                b_raw_ff;
   logic                         a_load, b_load;
   logic [salc_pkg::SHIFT_W-1:0] shift_sum;
   logic [salc_pkg::TAG_W-1:0]   split_tag;
   logic [RW:0]                  set_mask;
   logic [RW-1:0]                split_raw;
   logic [RW-1:0]                a_red, b_red;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= salc_pkg::LINE_OFFSET_RESET;
         sib_ff <= salc_pkg::SET_INDEX_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == salc_pkg::CSR_LINE_OFFSET) begin
            off_ff <= csr_wdata;
         end
         if (csr_index == salc_pkg::CSR_SET_INDEX) begin
            sib_ff <= csr_wdata;
         end
      end
   end

   // address split; offset plus index is at most 30, so the shift stays in range
   assign shift_sum = salc_pkg::SHIFT_W'(off_ff) + salc_pkg::SHIFT_W'(sib_ff);
   assign split_tag = in_address >> shift_sum;
   assign set_mask  = ((RW + 1)'(1) << sib_ff) - (RW + 1)'(1);
   assign split_raw = RW'(in_address >> off_ff) & set_mask[RW-1:0];

   // two-stage pipe into the queue
   assign b_load  = !b_valid_ff || !q_full;
   assign a_load  = !a_valid_ff || b_load;
   assign in_full = !a_load;
   assign q_push  = b_valid_ff;
   assign q_tag   = b_tag_ff;

   assign a_valid_in = a_load ? in_push : a_valid_ff;
   assign b_valid_in = b_load ? a_valid_ff : b_valid_ff;

   // set index modulo MAX_SETS by conditional subtraction, high steps here
   always_comb begin
      a_red = a_raw_ff;
      for (int k = RW - 1; k >= 8; k--) begin
         if ((MAX_SETS << k) < (1 << RW)) begin
            if (a_red >= RW'(MAX_SETS << k)) begin
               a_red = a_red - RW'(MAX_SETS << k);
            end
         end
      end
   end

   // low steps after the stage register
   always_comb begin
      b_red = b_raw_ff;
      for (int k = 7; k >= 0; k--) begin
         if ((MAX_SETS << k) < (1 << RW)) begin
            if (b_red >= RW'(MAX_SETS << k)) begin
               b_red = b_red - RW'(MAX_SETS << k);
            end
         end
      end
   end

   assign q_set = SET_W'(b_red);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load && in_push) begin
         a_tag_ff <= split_tag;
         a_raw_ff <= split_raw;
      end
      if (b_load && a_valid_ff) begin
         b_tag_ff <= a_tag_ff;
         b_raw_ff <= a_red;
      end
   end

endmodule

`default_nettype wire

// ===== design/salc_back.sv =====
// Back end: read a set row, match ways, pick victim, age update, write back.
// Depends on salc_pkg; drives the tag row memory and the response queue.
`timescale 1ns / 1ps
`default_nettype none

module salc_back #(
   parameter int WAYS = 8,
   parameter int MAX_SETS = 256,
   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
   localparam int ROW_W = WAYS * salc_pkg::ENTRY_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire logic [salc_pkg::TAG_W-1:0]   q_tag,
   input  wire logic [SET_W-1:0]             q_set,
   output logic                              q_pop,
   input  wire logic                         out_full,
   output logic                              out_push,
   output salc_pkg::rsp_type                 out_data,
   output logic                              clearing,
   output logic                              ram_wr_en,
   output logic      [SET_W-1:0]             ram_wr_addr,
   output logic      [ROW_W-1:0]             ram_wr_data,
   output logic                              ram_rd_en,
   output logic      [SET_W-1:0]             ram_rd_addr,
   input  wire logic [ROW_W-1:0]             ram_rd_data
);

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AW    = salc_pkg::AGE_W;

   salc_pkg::back_state_type state_ff, state_in;

   logic [SET_W-1:0]           clr_ff, clr_in;
   logic [salc_pkg::TAG_W-1:0] cur_tag_ff;
   logic [SET_W-1:0]           cur_set_ff;
   logic                       start;

   salc_pkg::way_entry_type [WAYS-1:0] rd_row, row_ff, new_row;

   logic [WAYS-1:0]  match, empty_way;
   logic             any_hit, any_empty;
   logic [WAY_W-1:0] hit_way, empty_sel, old_way;
   logic [(1 << AW)-1:0] age_seen;
   logic [AW-1:0]    oldest;

   logic             hit_in, hit_ff;
   logic             evict_in, evict_ff;
   logic [WAY_W-1:0] use_in, use_ff;
   logic [AW:0]      prev_in, prev_ff;
   logic [WAY_W+salc_pkg::WAY_OUT_W-1:0] way_wide;

   assign rd_row = ram_rd_data;
   assign start  = !q_empty && !out_full;

   // way match, first empty way, and oldest way over the row just read
   always_comb begin
      hit_way   = '0;
      empty_sel = '0;
      old_way   = '0;
      oldest    = '0;
      age_seen  = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w]     = rd_row[w].valid && (rd_row[w].tag == cur_tag_ff);
         empty_way[w] = !rd_row[w].valid;
         age_seen[rd_row[w].age] = 1'b1;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_way[w]) begin
            empty_sel = WAY_W'(w);
         end
      end
      for (int a = 0; a < (1 << AW); a++) begin
         if (age_seen[a]) begin
            oldest = AW'(a);
         end
      end
      // ties go to the highest-numbered way
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row[w].age == oldest) begin
            old_way = WAY_W'(w);
         end
      end
   end

   assign any_hit   = |match;
   assign any_empty = |empty_way;

   always_comb begin
      hit_in   = any_hit;
      evict_in = 1'b0;
      if (any_hit) begin
         use_in  = hit_way;
         prev_in = {1'b0, rd_row[hit_way].age};
      end else if (any_empty) begin
         // a fill counts as older than every rank
         use_in  = empty_sel;
         prev_in = {1'b1, {AW{1'b0}}};
      end else begin
         use_in   = old_way;
         prev_in  = {1'b0, oldest};
         evict_in = 1'b1;
      end
   end

   // new row: used way youngest, younger valid ways age by one, saturating
   always_comb begin
      new_row = row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == use_ff) begin
            new_row[w].valid = 1'b1;
            new_row[w].age   = '0;
            new_row[w].tag   = cur_tag_ff;
         end else if (row_ff[w].valid && ({1'b0, row_ff[w].age} < prev_ff)
                      && (row_ff[w].age != salc_pkg::AGE_MAX)) begin
            new_row[w].age = row_ff[w].age + 1'b1;
         end
      end
   end

   assign way_wide = {{salc_pkg::WAY_OUT_W{1'b0}}, use_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         salc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = salc_pkg::ST_LOOK;
            end
         end
         salc_pkg::ST_LOOK:   state_in = salc_pkg::ST_UPDATE;
         salc_pkg::ST_UPDATE: state_in = salc_pkg::ST_IDLE;
         default:             state_in = salc_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      q_pop       = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = q_set;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_set_ff;
      ram_wr_data = new_row;
      out_push    = 1'b0;
      clearing    = 1'b0;
      clr_in      = clr_ff;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            clearing    = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
         end
         salc_pkg::ST_IDLE: begin
            q_pop     = start;
            ram_rd_en = start;
         end
         salc_pkg::ST_UPDATE: begin
            ram_wr_en = 1'b1;
            out_push  = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   assign out_data.hit      = hit_ff;
   assign out_data.way_used = way_wide[salc_pkg::WAY_OUT_W-1:0];
   assign out_data.evicted  = evict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salc_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_tag_ff <= q_tag;
         cur_set_ff <= q_set;
      end
      if (state_ff == salc_pkg::ST_LOOK) begin
         row_ff   <= rd_row;
         hit_ff   <= hit_in;
         evict_ff <= evict_in;
         use_ff   <= use_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/lru_tag_mirror_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class for the LRU tag store lookup: keeps its own copy of the
// per-way valid, tag and age state and the split registers. Depends on salc_pkg.

package lru_tag_mirror_pkg;

   import salc_pkg::*;

   localparam int WAYS     = 8;
   localparam int MAX_SETS = 256;
   localparam int ENTRIES  = WAYS * MAX_SETS;

   class lru_tag_mirror;
      logic [CFG_W-1:0] off_bits;
      logic [CFG_W-1:0] idx_bits;
      bit               way_valid [ENTRIES];
      logic [TAG_W-1:0] way_tag [ENTRIES];
      logic [AGE_W-1:0] way_age [ENTRIES];
      rsp_type          pending_rsp [$];
      int               errors;

      function new();
         off_bits = LINE_OFFSET_RESET;
         idx_bits = SET_INDEX_RESET;
         errors   = 0;
         for (int e = 0; e < ENTRIES; e++) begin
            way_valid[e] = 1'b0;
            way_tag[e]   = '0;
            way_age[e]   = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_LINE_OFFSET) begin
            off_bits = val;
         end else if (idx == CSR_SET_INDEX) begin
            idx_bits = val;
         end
      endfunction

      // accessed way goes to age 0; valid ways younger than its old age grow
      function void promote(int base, int sel, int prev_age);
         for (int w = 0; w < WAYS; w++) begin
            if (w != sel && way_valid[base + w] && way_age[base + w] < prev_age
                  && way_age[base + w] < AGE_MAX) begin
               way_age[base + w] = way_age[base + w] + 1'b1;
            end
         end
         way_age[base + sel] = '0;
      endfunction

      function void note_lookup(logic [ADDR_W-1:0] addr);
         int unsigned          shift;
         int                   base;
         int                   pick;
         logic [TAG_W-1:0]     tag;
         logic [RAW_SET_W-1:0] raw_set;
         logic [AGE_W-1:0]     oldest;
         rsp_type              r;
         bit                   done;
         shift   = off_bits + idx_bits;
         tag     = addr >> shift;
         raw_set = (addr >> off_bits) & ((32'd1 << idx_bits) - 32'd1);
         base    = (raw_set % MAX_SETS) * WAYS;
         r       = '0;
         done    = 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            if (!done && way_valid[base + w] && way_tag[base + w] == tag) begin
               promote(base, w, way_age[base + w]);
               r.hit      = 1'b1;
               r.way_used = w[WAY_OUT_W-1:0];
               done       = 1'b1;
            end
         end
         // miss: first free way, counted older than any rank
         for (int w = 0; w < WAYS; w++) begin
            if (!done && !way_valid[base + w]) begin
               way_valid[base + w] = 1'b1;
               way_tag[base + w]   = tag;
               promote(base, w, AGE_MAX + 1);
               r.way_used = w[WAY_OUT_W-1:0];
               done       = 1'b1;
            end
         end
         // set full: replace the oldest, highest way wins a tie
         if (!done) begin
            pick   = 0;
            oldest = '0;
            for (int w = 0; w < WAYS; w++) begin
               if (w == 0 || way_age[base + w] >= oldest) begin
                  oldest = way_age[base + w];
                  pick   = w;
               end
            end
            way_tag[base + pick] = tag;
            promote(base, pick, oldest);
            r.way_used = pick[WAY_OUT_W-1:0];
            r.evicted  = 1'b1;
         end
         pending_rsp = {pending_rsp, r};
      endfunction

      function void check_rsp(logic hit, logic [WAY_OUT_W-1:0] way, logic evicted);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response popped with no request pending");
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, hit);
            errors++;
         end
         if (way !== want.way_used) begin
            $error("way_used: expected %0d, actual %0d", want.way_used, way);
            errors++;
         end
         if (evicted !== want.evicted) begin
            $error("evicted: expected %0d, actual %0d", want.evicted, evicted);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top-level bench for set_assoc_cache_lru_lookup: directed and random address
// streams over several split settings. Depends on salc_pkg, lru_tag_mirror_pkg.

module tb;

   import salc_pkg::*;
   import lru_tag_mirror_pkg::*;

   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int TAG_POOL        = 10;

   // split settings per random phase: extremes, above-range values, middles
   localparam int PHASE_OFF [NUM_PHASES] = '{0, 12, 15, 3, 9, 2};
   localparam int PHASE_SIB [NUM_PHASES] = '{0, 8, 15, 4, 11, 1};

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 push        = 1'b0;
   logic                 pop         = 1'b0;
   logic [ADDR_W-1:0]    req_address = '0;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_LINE_OFFSET;
   logic [CFG_W-1:0]     csr_wdata   = '0;
   logic                 full;
   logic                 empty;
   logic                 rsp_hit;
   logic [WAY_OUT_W-1:0] rsp_way_used;
   logic                 rsp_evicted;

   // idle odds in percent for each side, changed per phase
   int tx_idle_pct = 21;
   int rx_idle_pct = 66;

   // split currently programmed, used to shape addresses
   int cur_off = LINE_OFFSET_RESET;
   int cur_sib = SET_INDEX_RESET;

   logic [TAG_W-1:0] tag_pool [TAG_POOL];

   lru_tag_mirror mirror = new();

   set_assoc_cache_lru_lookup #(
      .WAYS(WAYS),
      .MAX_SETS(MAX_SETS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_address(req_address),
      .empty(empty),
      .pop(pop),
      .rsp_hit(rsp_hit),
      .rsp_way_used(rsp_way_used),
      .rsp_evicted(rsp_evicted),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // hard stop; includes the clearing pass after reset
   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

   // Response side: pop is decided before the edge it acts on, sampled values are pre-edge.
   initial begin
      forever begin
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
         @(posedge clock);
         if (pop && !empty) begin
            mirror.check_rsp(rsp_hit, rsp_way_used, rsp_evicted);
         end
      end
   end

   // each cycle the sender idles with the current odds
   function automatic int pick_gap();
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct) begin
         gap++;
      end
      return gap;
   endfunction

   // Holds push high until full is seen low at an edge. A gap first lowers
   // push, so push is never lowered and raised within one time step.
   task automatic send_request(logic [ADDR_W-1:0] addr, int gap);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push        <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (full) @(posedge clock);
      mirror.note_lookup(addr);
   endtask

   // sender stops and waits until every queued response has been popped
   task automatic wait_drained();
      push <= 1'b0;
      while (mirror.pending_rsp.size() != 0) @(posedge clock);
   endtask

   // both split registers back to back; only called with the block idle
   task automatic write_split(int off, int sib);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LINE_OFFSET;
      csr_wdata <= off[CFG_W-1:0];
      @(posedge clock);
      mirror.write_reg(CSR_LINE_OFFSET, off[CFG_W-1:0]);
      csr_index <= CSR_SET_INDEX;
      csr_wdata <= sib[CFG_W-1:0];
      @(posedge clock);
      mirror.write_reg(CSR_SET_INDEX, sib[CFG_W-1:0]);
      csr_wr_en <= 1'b0;
      cur_off = off;
      cur_sib = sib;
   endtask

   // Mostly well-formed traffic: a few hot sets and a small tag pool, so
   // lines hit, fill and get evicted. High set bits beyond MAX_SETS make
   // aliased sets; some fully random addresses are mixed in as noise.
   function automatic logic [ADDR_W-1:0] make_address();
      logic [TAG_W-1:0]  tag_val;
      logic [31:0]       raw_set;
      logic [31:0]       low;
      int unsigned       shift;
      if ($urandom_range(0, 99) < 12) begin
         return $urandom();
      end
      shift   = cur_off + cur_sib;
      tag_val = tag_pool[$urandom_range(0, TAG_POOL - 1)];
      raw_set = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 25) begin
         raw_set = raw_set | ($urandom() << 8);
      end
      raw_set = raw_set & ((32'd1 << cur_sib) - 32'd1);
      low     = $urandom() & ((32'd1 << cur_off) - 32'd1);
      return (tag_val << shift) | (raw_set << cur_off) | low;
   endfunction

   initial begin
      logic [ADDR_W-1:0] directed [$];

      // Directed list under the reset split (offset 6, index 6):
      // address extremes, same-line hit, fill of all free ways in set 0,
      // eviction of the oldest, hit on an aged line, refill after eviction.
      directed = {directed, 32'h0000_0000};
      directed = {directed, 32'h0000_0000};
      directed = {directed, 32'hFFFF_FFFF};
      directed = {directed, 32'h0000_003F};
      for (int t = 1; t <= 8; t++) begin
         directed = {directed, ADDR_W'(t << 12)};
      end
      directed = {directed, 32'h0000_3000};
      directed = {directed, 32'h0000_9000};
      directed = {directed, 32'hFFFF_FFFF};
      directed = {directed, 32'h8000_0000};
      directed = {directed, 32'h7FFF_FFFF};
      directed = {directed, 32'h0000_0000};
      directed = {directed, 32'h0000_1040};
      directed = {directed, 32'h0000_2000};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // full stays high through the clearing pass; send_request waits on it
      foreach (directed[i]) begin
         send_request(directed[i], pick_gap());
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // idle between phases: every response in before the split changes
         wait_drained();
         write_split(PHASE_OFF[p], PHASE_SIB[p]);
         if (p < 2) begin
            tx_idle_pct = 21;
            rx_idle_pct = 66;
         end else if (p < 4) begin
            tx_idle_pct = 66;
            rx_idle_pct = 21;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (int k = 0; k < TAG_POOL; k++) begin
            tag_pool[k] = (k < 4) ? k : $urandom();
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_request(make_address(), pick_gap());
         end
      end

      wait_drained();
      // catch any response that shows up late without a request behind it
      repeat (20) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending_rsp.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
